>>> rtl/cipso_pkg.sv
// Shared types and constants for the CIPSO IPv4 frame parser.
// No dependencies; every other file refers to this package by scoped names.
package cipso_pkg;

  localparam int unsigned FRAME_BYTES = 2048;
  localparam int unsigned OFF_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [2:0] KIND_BITMAP  = 3'd0;
  localparam logic [2:0] KIND_ENUM    = 3'd1;
  localparam logic [2:0] KIND_RANGE   = 3'd2;
  localparam logic [2:0] KIND_SUMMARY = 3'd3;
  localparam logic [2:0] KIND_REJECT  = 3'd4;

  localparam logic [1:0] CFG_OPT_TYPE  = 2'd0;
  localparam logic [1:0] CFG_TAG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ETH_TYPE  = 2'd2;

  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [7:0]  TAG_BITMAP = 8'd1;
  localparam logic [7:0]  TAG_ENUM   = 8'd2;
  localparam logic [7:0]  TAG_RANGE  = 8'd5;
  localparam logic [7:0]  OPT_EOL    = 8'd0;
  localparam logic [7:0]  OPT_NOP    = 8'd1;

  typedef enum logic [3:0] {
    PH_ETH, PH_IP, PH_OPT_TYPE, PH_OPT_LEN, PH_OPT_SKIP, PH_SEC_LEN, PH_DOI,
    PH_TAG_TYPE, PH_TAG_LEN, PH_TAG_ALIGN, PH_TAG_LEVEL, PH_TAG_BODY,
    PH_HDR_SKIP, PH_PAYLOAD, PH_DRAIN
  } phase_e;

  // Records caused by one frame byte: category records first, then an
  // optional summary or reject.
  typedef struct packed {
    logic [7:0]  cat_mask;   // bit i set: one category record in slot i
    logic        is_bitmap;  // categories are cat_first + slot
    logic [2:0]  cat_kind;
    logic [7:0]  tag_kind;
    logic [31:0] cat_domain;
    logic [7:0]  sens_level;
    logic [15:0] cat_first;
    logic [15:0] cat_second;
    logic        has_fin;
    logic [2:0]  fin_kind;
    logic [31:0] fin_domain;
    logic [7:0]  proto_num;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } bundle_t;

endpackage

>>> rtl/cipso_parser.sv
// Byte parser: frame state, configuration registers and per-byte record bundle.
// Depends on cipso_pkg.
module cipso_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            byte_i,
  input  logic                  end_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  push_o,
  output cipso_pkg::bundle_t    bundle_o
);

  logic [7:0]  opt_code_q;
  logic [3:0]  tag_limit_q;
  logic [15:0] eth_type_q;

  logic [cipso_pkg::OFF_W-1:0] off_q, off_d;
  cipso_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hw_q, hw_d;
  logic [5:0]  cur_q, cur_d;
  logic [7:0]  optl_q, optl_d;
  logic [7:0]  ttype_q, ttype_d;
  logic [7:0]  tagl_q, tagl_d;
  logic [3:0]  tcnt_q, tcnt_d;
  logic [31:0] dom_q, dom_d;
  logic [7:0]  lvl_q, lvl_d;
  logic [15:0] wsh_q, wsh_d;
  logic [15:0] rtop_q, rtop_d;
  logic [7:0]  bidx_q, bidx_d;
  logic [31:0] src_q, src_d, dst_q, dst_d;
  logic [15:0] sp_q, sp_d, dp_q, dp_d;
  logic [7:0]  proto_q, proto_d;
  logic        found_q, found_d, ports_q, ports_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_code_q  <= 8'd134;
      tag_limit_q <= 4'd10;
      eth_type_q  <= 16'h0800;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cipso_pkg::CFG_OPT_TYPE:  opt_code_q  <= cfg_data_i[7:0];
        cipso_pkg::CFG_TAG_LIMIT: tag_limit_q <= cfg_data_i[3:0];
        cipso_pkg::CFG_ETH_TYPE:  eth_type_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [5:0] area;
    logic [5:0] hbytes;
    logic [cipso_pkg::OFF_W-1:0] p;
    logic       oend;
    logic       lastb;
    logic [6:0] cur1;
    logic [5:0] rem;
    logic [7:0] len;
    logic [15:0] w;
    logic       ok;
    cipso_pkg::bundle_t bd;

    off_d = off_q; phase_d = phase_q; hw_d = hw_q; cur_d = cur_q; optl_d = optl_q;
    ttype_d = ttype_q; tagl_d = tagl_q; tcnt_d = tcnt_q; dom_d = dom_q;
    lvl_d = lvl_q; wsh_d = wsh_q; rtop_d = rtop_q; bidx_d = bidx_q;
    src_d = src_q; dst_d = dst_q; sp_d = sp_q; dp_d = dp_q; proto_d = proto_q;
    found_d = found_q; ports_d = ports_q;
    bd = '0;
    oend = 1'b0;
    lastb = 1'b0;
    w = '0;
    ok = 1'b0;
    cur1 = '0;
    rem = '0;
    len = '0;
    p = '0;
    area = (hw_q > 4'd5) ? {hw_q - 4'd5, 2'b00} : 6'd0;
    hbytes = (hw_q > 4'd5) ? {hw_q, 2'b00} : 6'd20;

    if (off_q < cipso_pkg::OFF_W'(cipso_pkg::FRAME_BYTES)) begin
      if (phase_q == cipso_pkg::PH_ETH) begin
        if (off_q == cipso_pkg::OFF_W'(12)) wsh_d = {8'd0, byte_i};
        if (off_q == cipso_pkg::OFF_W'(13)) begin
          wsh_d = {wsh_q[7:0], byte_i};
          phase_d = (wsh_d == eth_type_q) ? cipso_pkg::PH_IP : cipso_pkg::PH_DRAIN;
        end
      end else if (phase_q == cipso_pkg::PH_IP) begin
        p = off_q - cipso_pkg::OFF_W'(14);
        if (p == cipso_pkg::OFF_W'(0)) hw_d = byte_i[3:0];
        else if (p == cipso_pkg::OFF_W'(9)) proto_d = byte_i;
        else if (p >= cipso_pkg::OFF_W'(12) && p <= cipso_pkg::OFF_W'(15))
          src_d = {src_q[23:0], byte_i};
        else if (p >= cipso_pkg::OFF_W'(16) && p <= cipso_pkg::OFF_W'(19))
          dst_d = {dst_q[23:0], byte_i};
        if (p == cipso_pkg::OFF_W'(19)) begin
          cur_d = '0;
          phase_d = (area != 6'd0) ? cipso_pkg::PH_OPT_TYPE : cipso_pkg::PH_PAYLOAD;
        end
      end else if (phase_q >= cipso_pkg::PH_OPT_TYPE && phase_q <= cipso_pkg::PH_HDR_SKIP) begin
        // Bytes inside the security option also count down its length.
        if (phase_q >= cipso_pkg::PH_DOI && phase_q <= cipso_pkg::PH_TAG_BODY) begin
          optl_d = optl_q - 8'd1;
          oend = (optl_d == 8'd0);
        end
        unique case (phase_q)
          cipso_pkg::PH_OPT_TYPE: begin
            if (byte_i == opt_code_q) begin
              found_d = 1'b1;
              phase_d = cipso_pkg::PH_SEC_LEN;
            end else if (byte_i == cipso_pkg::OPT_EOL) begin
              phase_d = cipso_pkg::PH_HDR_SKIP;
            end else if (byte_i != cipso_pkg::OPT_NOP) begin
              phase_d = cipso_pkg::PH_OPT_LEN;
            end
          end
          cipso_pkg::PH_OPT_LEN: begin
            if (byte_i < 8'd2) begin
              phase_d = cipso_pkg::PH_DRAIN;
            end else begin
              optl_d = byte_i - 8'd2;
              phase_d = (optl_d != 8'd0) ? cipso_pkg::PH_OPT_SKIP : cipso_pkg::PH_OPT_TYPE;
            end
          end
          cipso_pkg::PH_OPT_SKIP: begin
            optl_d = optl_q - 8'd1;
            if (optl_d == 8'd0) phase_d = cipso_pkg::PH_OPT_TYPE;
          end
          cipso_pkg::PH_SEC_LEN: begin
            if (byte_i < 8'd2) begin
              phase_d = cipso_pkg::PH_DRAIN;
            end else begin
              len = byte_i - 8'd2;
              cur1 = {1'b0, cur_q} + 7'd1;
              rem = (cur1 < {1'b0, area}) ? (area - cur_q - 6'd1) : 6'd0;
              optl_d = (len < {2'b00, rem}) ? len : {2'b00, rem};
              dom_d = '0;
              bidx_d = '0;
              phase_d = (optl_d != 8'd0) ? cipso_pkg::PH_DOI : cipso_pkg::PH_HDR_SKIP;
            end
          end
          cipso_pkg::PH_DOI: begin
            dom_d = {dom_q[23:0], byte_i};
            bidx_d = bidx_q + 8'd1;
            if (bidx_d >= 8'd4) phase_d = cipso_pkg::PH_TAG_TYPE;
          end
          cipso_pkg::PH_TAG_TYPE: begin
            if (tcnt_q >= tag_limit_q || (byte_i != cipso_pkg::TAG_BITMAP &&
                byte_i != cipso_pkg::TAG_ENUM && byte_i != cipso_pkg::TAG_RANGE)) begin
              phase_d = cipso_pkg::PH_HDR_SKIP;
            end else begin
              tcnt_d = tcnt_q + 4'd1;
              ttype_d = byte_i;
              phase_d = cipso_pkg::PH_TAG_LEN;
            end
          end
          cipso_pkg::PH_TAG_LEN: begin
            if (byte_i < 8'd4) begin
              phase_d = cipso_pkg::PH_HDR_SKIP;
            end else begin
              tagl_d = byte_i - 8'd2;
              phase_d = cipso_pkg::PH_TAG_ALIGN;
            end
          end
          cipso_pkg::PH_TAG_ALIGN: begin
            tagl_d = tagl_q - 8'd1;
            phase_d = cipso_pkg::PH_TAG_LEVEL;
          end
          cipso_pkg::PH_TAG_LEVEL: begin
            lvl_d = byte_i;
            tagl_d = tagl_q - 8'd1;
            bidx_d = '0;
            phase_d = (tagl_d != 8'd0) ? cipso_pkg::PH_TAG_BODY : cipso_pkg::PH_TAG_TYPE;
          end
          cipso_pkg::PH_TAG_BODY: begin
            tagl_d = tagl_q - 8'd1;
            lastb = (tagl_d == 8'd0) || oend;
            bd.tag_kind = ttype_q;
            bd.cat_domain = dom_q;
            bd.sens_level = lvl_q;
            if (ttype_q == cipso_pkg::TAG_BITMAP) begin
              // Slot i carries the bit read i places from the top.
              for (int i = 0; i < 8; i++) bd.cat_mask[i] = byte_i[7-i];
              bd.is_bitmap = 1'b1;
              bd.cat_kind = cipso_pkg::KIND_BITMAP;
              bd.cat_first = {5'd0, bidx_q, 3'd0};
            end else if (ttype_q == cipso_pkg::TAG_ENUM) begin
              if (bidx_q[0]) begin
                w = {wsh_q[7:0], byte_i};
                bd.cat_mask = 8'd1;
                bd.cat_kind = cipso_pkg::KIND_ENUM;
                bd.cat_first = w;
                bd.cat_second = w;
              end else begin
                wsh_d = {8'd0, byte_i};
              end
            end else begin
              bd.cat_kind = cipso_pkg::KIND_RANGE;
              unique case (bidx_q[1:0])
                2'd0: wsh_d = {8'd0, byte_i};
                2'd1: begin
                  rtop_d = {wsh_q[7:0], byte_i};
                  if (lastb) begin
                    bd.cat_mask = 8'd1;
                    bd.cat_first = rtop_d;
                  end
                end
                2'd2: begin
                  wsh_d = {8'd0, byte_i};
                  if (lastb) begin
                    bd.cat_mask = 8'd1;
                    bd.cat_first = rtop_q;
                  end
                end
                default: begin
                  bd.cat_mask = 8'd1;
                  bd.cat_first = rtop_q;
                  bd.cat_second = {wsh_q[7:0], byte_i};
                end
              endcase
            end
            bidx_d = bidx_q + 8'd1;
            if (tagl_d == 8'd0) phase_d = cipso_pkg::PH_TAG_TYPE;
          end
          default: ;
        endcase
        if (oend && phase_d != cipso_pkg::PH_DRAIN) phase_d = cipso_pkg::PH_HDR_SKIP;
        cur_d = cur_q + 6'd1;
        if (cur_d >= area && phase_d != cipso_pkg::PH_DRAIN) phase_d = cipso_pkg::PH_PAYLOAD;
      end else if (phase_q == cipso_pkg::PH_PAYLOAD && proto_q == cipso_pkg::PROTO_UDP) begin
        p = off_q - cipso_pkg::OFF_W'(14) - cipso_pkg::OFF_W'(hbytes);
        if (p < cipso_pkg::OFF_W'(2)) sp_d = {sp_q[7:0], byte_i};
        else if (p < cipso_pkg::OFF_W'(4)) dp_d = {dp_q[7:0], byte_i};
        if (p == cipso_pkg::OFF_W'(3)) ports_d = 1'b1;
      end
      off_d = off_q + cipso_pkg::OFF_W'(1);
    end

    if (end_i) begin
      ok = (phase_d == cipso_pkg::PH_PAYLOAD) && found_d &&
           (proto_d != cipso_pkg::PROTO_UDP || ports_d);
      bd.has_fin = 1'b1;
      if (ok) begin
        bd.fin_kind = cipso_pkg::KIND_SUMMARY;
        bd.fin_domain = dom_d;
        bd.proto_num = proto_d;
        bd.source_addr = src_d;
        bd.dest_addr = dst_d;
        if (proto_d == cipso_pkg::PROTO_UDP) begin
          bd.source_port = sp_d;
          bd.dest_port = dp_d;
        end
      end else begin
        bd.fin_kind = cipso_pkg::KIND_REJECT;
      end
      off_d = '0; phase_d = cipso_pkg::PH_ETH; hw_d = '0; cur_d = '0; optl_d = '0;
      ttype_d = '0; tagl_d = '0; tcnt_d = '0; dom_d = '0; lvl_d = '0; wsh_d = '0;
      rtop_d = '0; bidx_d = '0; src_d = '0; dst_d = '0; sp_d = '0; dp_d = '0;
      proto_d = '0; found_d = 1'b0; ports_d = 1'b0;
    end
    bundle_o = bd;
    push_o = take_i && ((bd.cat_mask != 8'd0) || bd.has_fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; phase_q <= cipso_pkg::PH_ETH; hw_q <= '0; cur_q <= '0; optl_q <= '0;
      ttype_q <= '0; tagl_q <= '0; tcnt_q <= '0; dom_q <= '0; lvl_q <= '0;
      wsh_q <= '0; rtop_q <= '0; bidx_q <= '0; src_q <= '0; dst_q <= '0;
      sp_q <= '0; dp_q <= '0; proto_q <= '0; found_q <= 1'b0; ports_q <= 1'b0;
    end else if (take_i) begin
      off_q <= off_d; phase_q <= phase_d; hw_q <= hw_d; cur_q <= cur_d; optl_q <= optl_d;
      ttype_q <= ttype_d; tagl_q <= tagl_d; tcnt_q <= tcnt_d; dom_q <= dom_d;
      lvl_q <= lvl_d; wsh_q <= wsh_d; rtop_q <= rtop_d; bidx_q <= bidx_d;
      src_q <= src_d; dst_q <= dst_d; sp_q <= sp_d; dp_q <= dp_d; proto_q <= proto_d;
      found_q <= found_d; ports_q <= ports_d;
    end
  end

endmodule

>>> rtl/cipso_fifo.sv
// Small queue of per-byte record bundles between parser and serializer.
// Depends on cipso_pkg.
module cipso_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cipso_pkg::bundle_t data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output cipso_pkg::bundle_t head_o
);

  cipso_pkg::bundle_t mem_q [cipso_pkg::FIFO_DEPTH];
  logic [cipso_pkg::PTR_W-1:0] wr_q, rd_q;
  logic [cipso_pkg::PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (cipso_pkg::PTR_W+1)'(cipso_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + cipso_pkg::PTR_W'(1);
      if (pop_i) rd_q <= rd_q + cipso_pkg::PTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10: cnt_q <= cnt_q + (cipso_pkg::PTR_W+1)'(1);
        2'b01: cnt_q <= cnt_q - (cipso_pkg::PTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/cipso_serializer.sv
// Walks the head bundle and presents one record per transfer.
// Depends on cipso_pkg.
module cipso_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  cipso_pkg::bundle_t head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [183:0]       m_axis_tdata,
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [7:0] done_q, done_d;
  logic [7:0] left;
  logic [7:0] rest;
  logic [2:0] slot;
  logic       is_cat;
  logic       last;
  logic [15:0] c1, c2;

  always_comb begin
    left = head_i.cat_mask & ~done_q;
    slot = '0;
    for (int i = 7; i >= 0; i--) if (left[i]) slot = 3'(i);
    rest = left & ~(8'd1 << slot);
    is_cat = (left != 8'd0);
    last = is_cat ? ((rest == 8'd0) && !head_i.has_fin) : 1'b1;
    c1 = head_i.is_bitmap ? (head_i.cat_first + {13'd0, slot}) : head_i.cat_first;
    c2 = head_i.is_bitmap ? c1 : head_i.cat_second;
    m_axis_tvalid = !empty_i;
    m_axis_tlast = last;
    if (is_cat) begin
      m_axis_tuser = head_i.cat_kind;
      m_axis_tdata = {16'd0, 16'd0, 32'd0, 32'd0, 8'd0, c2, c1,
                      head_i.sens_level, head_i.cat_domain, head_i.tag_kind};
    end else begin
      m_axis_tuser = head_i.fin_kind;
      m_axis_tdata = {head_i.dest_port, head_i.source_port, head_i.dest_addr,
                      head_i.source_addr, head_i.proto_num, 16'd0, 16'd0, 8'd0,
                      head_i.fin_domain, 8'd0};
    end
    pop_o = m_axis_tvalid && m_axis_tready && last;
    done_d = done_q;
    if (m_axis_tvalid && m_axis_tready) done_d = last ? 8'd0 : (done_q | (8'd1 << slot));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= '0;
    else done_q <= done_d;
  end

endmodule

>>> rtl/cipso_ipv4_frame_parser_unit.sv
// CIPSO IPv4 frame parser top level: parser, bundle queue and record serializer.
// Depends on cipso_pkg, cipso_parser, cipso_fifo and cipso_serializer.
// Throughput: one frame byte per cycle while the bundle queue has room.
// A byte's records are written into the bundle queue and presented from its head.
// Records leave at one per cycle while m_axis_tready is high; a byte that causes
// up to nine records queues them in a four-entry bundle queue, which stalls input
// only when full. Reset clears all frame state and loads the register defaults.
module cipso_ipv4_frame_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte
  input  logic         s_axis_tlast,   // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tag_kind, domain_id, sens_level, cat_first, cat_second, proto_num,
  // source_addr, dest_addr, source_port, dest_port
  output logic [183:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // record_kind
  output logic         m_axis_tlast,   // run_last
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic take, push, pop, full, empty;
  cipso_pkg::bundle_t bundle, head;

  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  cipso_parser u_parser (
    .clk_i, .rst_ni,
    .take_i(take), .byte_i(s_axis_tdata), .end_i(s_axis_tlast),
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .push_o(push), .bundle_o(bundle)
  );

  cipso_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(bundle), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head)
  );

  cipso_serializer u_ser (
    .clk_i, .rst_ni,
    .empty_i(empty), .head_i(head), .pop_o(pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule
